/* rtl/core/sri_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, register indexes and flag types for the segment/rectangle test.
package sri_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int CFG_INDEX_W     = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_A_X = 2'd0,
    CFG_A_Y = 2'd1,
    CFG_B_X = 2'd2,
    CFG_B_Y = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic endpoint_in;
    logic ey_lo;
    logic ey_hi;
    logic ex_lo;
    logic ex_hi;
    logic flat_y;
    logic flat_x;
    logic ov_x;
    logic ov_y;
    logic neg_x;
    logic neg_y;
  } sri_flags_t;

endpackage

/* rtl/core/sri_cfg.sv */
`timescale 1ns / 1ps
// Corner registers and the ordered rectangle bounds derived from them.
module sri_cfg import sri_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  output logic signed [COORD_WIDTH-1:0] x_lo,
  output logic signed [COORD_WIDTH-1:0] x_hi,
  output logic signed [COORD_WIDTH-1:0] y_lo,
  output logic signed [COORD_WIDTH-1:0] y_hi
);

  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_x <= '0;
      a_y <= '0;
      b_x <= '0;
      b_y <= '0;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        CFG_A_X: a_x <= $signed(cfg_data);
        CFG_A_Y: a_y <= $signed(cfg_data);
        CFG_B_X: b_x <= $signed(cfg_data);
        CFG_B_Y: b_y <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    x_lo = (a_x < b_x) ? a_x : b_x;
    x_hi = (a_x < b_x) ? b_x : a_x;
    y_lo = (a_y < b_y) ? a_y : b_y;
    y_hi = (a_y < b_y) ? b_y : a_y;
  end

endmodule

/* rtl/core/sri_prep.sv */
`timescale 1ns / 1ps
// First stage: coordinate differences, range compares and edge-span flags.
module sri_prep import sri_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] x_lo,
  input  logic signed [COORD_WIDTH-1:0] x_hi,
  input  logic signed [COORD_WIDTH-1:0] y_lo,
  input  logic signed [COORD_WIDTH-1:0] y_hi,
  output logic signed [COORD_WIDTH:0]   dx,
  output logic signed [COORD_WIDTH:0]   dy,
  output logic signed [COORD_WIDTH:0]   dxp,
  output logic signed [COORD_WIDTH:0]   dxq,
  output logic signed [COORD_WIDTH:0]   dyp,
  output logic signed [COORD_WIDTH:0]   dyq,
  output sri_flags_t                    flags
);

  localparam int DW = COORD_WIDTH + 1;

  logic signed [DW-1:0] x1;
  logic signed [DW-1:0] y1;
  logic signed [DW-1:0] x2;
  logic signed [DW-1:0] y2;
  logic signed [DW-1:0] xl;
  logic signed [DW-1:0] xh;
  logic signed [DW-1:0] yl;
  logic signed [DW-1:0] yh;
  sri_flags_t           flags_next;

  always_comb begin
    x1 = $signed({start_x[COORD_WIDTH-1], start_x});
    y1 = $signed({start_y[COORD_WIDTH-1], start_y});
    x2 = $signed({end_x[COORD_WIDTH-1], end_x});
    y2 = $signed({end_y[COORD_WIDTH-1], end_y});
    xl = $signed({x_lo[COORD_WIDTH-1], x_lo});
    xh = $signed({x_hi[COORD_WIDTH-1], x_hi});
    yl = $signed({y_lo[COORD_WIDTH-1], y_lo});
    yh = $signed({y_hi[COORD_WIDTH-1], y_hi});

    flags_next.endpoint_in =
      (start_x >= x_lo && start_x <= x_hi && start_y >= y_lo && start_y <= y_hi) ||
      (end_x >= x_lo && end_x <= x_hi && end_y >= y_lo && end_y <= y_hi);
    flags_next.ey_lo = (start_y <= y_lo && y_lo <= end_y) || (end_y <= y_lo && y_lo <= start_y);
    flags_next.ey_hi = (start_y <= y_hi && y_hi <= end_y) || (end_y <= y_hi && y_hi <= start_y);
    flags_next.ex_lo = (start_x <= x_lo && x_lo <= end_x) || (end_x <= x_lo && x_lo <= start_x);
    flags_next.ex_hi = (start_x <= x_hi && x_hi <= end_x) || (end_x <= x_hi && x_hi <= start_x);
    flags_next.flat_y = (start_y == end_y);
    flags_next.flat_x = (start_x == end_x);
    flags_next.ov_x = (start_x >= x_lo || end_x >= x_lo) && (start_x <= x_hi || end_x <= x_hi);
    flags_next.ov_y = (start_y >= y_lo || end_y >= y_lo) && (start_y <= y_hi || end_y <= y_hi);
    flags_next.neg_x = (end_x < start_x);
    flags_next.neg_y = (end_y < start_y);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx    <= x2 - x1;
      dy    <= y2 - y1;
      dxp   <= x1 - xl;
      dxq   <= xh - x1;
      dyp   <= y1 - yl;
      dyq   <= yh - y1;
      flags <= flags_next;
    end
  end

endmodule

/* rtl/core/sri_prod.sv */
`timescale 1ns / 1ps
// Second stage: the four cross products shared among the edge tests.
module sri_prod import sri_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                adv,
  input  logic signed [COORD_WIDTH:0]         dx,
  input  logic signed [COORD_WIDTH:0]         dy,
  input  logic signed [COORD_WIDTH:0]         dxp,
  input  logic signed [COORD_WIDTH:0]         dxq,
  input  logic signed [COORD_WIDTH:0]         dyp,
  input  logic signed [COORD_WIDTH:0]         dyq,
  input  sri_flags_t                          flags_in,
  output logic signed [2*COORD_WIDTH+1:0]     xp_dy,
  output logic signed [2*COORD_WIDTH+1:0]     xq_dy,
  output logic signed [2*COORD_WIDTH+1:0]     yp_dx,
  output logic signed [2*COORD_WIDTH+1:0]     yq_dx,
  output sri_flags_t                          flags
);

  localparam int PW = 2 * (COORD_WIDTH + 1);

  logic signed [PW-1:0] xp_dy_next;
  logic signed [PW-1:0] xq_dy_next;
  logic signed [PW-1:0] yp_dx_next;
  logic signed [PW-1:0] yq_dx_next;

  always_comb begin
    xp_dy_next = PW'(dxp * dy);
    xq_dy_next = PW'(dxq * dy);
    yp_dx_next = PW'(dyp * dx);
    yq_dx_next = PW'(dyq * dx);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xp_dy <= xp_dy_next;
      xq_dy <= xq_dy_next;
      yp_dx <= yp_dx_next;
      yq_dx <= yq_dx_next;
      flags <= flags_in;
    end
  end

endmodule

/* rtl/core/sri_decide.sv */
`timescale 1ns / 1ps
// Third stage: crossing sums, sign tests per edge and the registered hit flag.
module sri_decide import sri_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            adv,
  input  logic signed [2*COORD_WIDTH+1:0] xp_dy,
  input  logic signed [2*COORD_WIDTH+1:0] xq_dy,
  input  logic signed [2*COORD_WIDTH+1:0] yp_dx,
  input  logic signed [2*COORD_WIDTH+1:0] yq_dx,
  input  sri_flags_t                      flags,
  output logic                            hit
);

  localparam int PW = 2 * (COORD_WIDTH + 1);
  localparam int SW = PW + 1;

  logic signed [SW-1:0] s1;
  logic signed [SW-1:0] s2;
  logic signed [SW-1:0] s3;
  logic signed [SW-1:0] s4;
  logic                 hit_y_lo;
  logic                 hit_y_hi;
  logic                 hit_x_lo;
  logic                 hit_x_hi;
  logic                 hit_next;

  function automatic logic sign_ok(input logic signed [SW-1:0] s, input logic neg);
    sign_ok = neg ? (s[SW-1] || (s == '0)) : !s[SW-1];
  endfunction

  always_comb begin
    s1 = SW'(xp_dy) - SW'(yp_dx);
    s2 = SW'(xq_dy) + SW'(yp_dx);
    s3 = SW'(xp_dy) + SW'(yq_dx);
    s4 = SW'(xq_dy) - SW'(yq_dx);

    hit_y_lo = flags.ey_lo && (flags.flat_y ? flags.ov_x :
               (sign_ok(s1, flags.neg_y) && sign_ok(s2, flags.neg_y)));
    hit_y_hi = flags.ey_hi && (flags.flat_y ? flags.ov_x :
               (sign_ok(s3, flags.neg_y) && sign_ok(s4, flags.neg_y)));
    hit_x_lo = flags.ex_lo && (flags.flat_x ? flags.ov_y :
               (sign_ok(s1, !flags.neg_x) && sign_ok(s3, flags.neg_x)));
    hit_x_hi = flags.ex_hi && (flags.flat_x ? flags.ov_y :
               (sign_ok(s2, flags.neg_x) && sign_ok(s4, !flags.neg_x)));

    hit_next = flags.endpoint_in || hit_y_lo || hit_y_hi || hit_x_lo || hit_x_hi;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= hit_next;
    end
  end

endmodule

/* rtl/core/segment_rect_intersect.sv */
`timescale 1ns / 1ps
// Segment against axis-aligned rectangle hit test, three register stages.
// A transaction passes the prep, prod and decide stage registers in that order.
// Throughput: one transaction per cycle; a stalled valid output holds every stage in place.
// Corners are ordered combinationally, so a write applies to the next transaction.
// Reset (rst, synchronous): clears corners and all stage valid bits.
module segment_rect_intersect import sri_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic                          adv;
  logic                          valid_a;
  logic                          valid_b;
  logic signed [COORD_WIDTH-1:0] x_lo;
  logic signed [COORD_WIDTH-1:0] x_hi;
  logic signed [COORD_WIDTH-1:0] y_lo;
  logic signed [COORD_WIDTH-1:0] y_hi;
  logic signed [DW-1:0]          dx;
  logic signed [DW-1:0]          dy;
  logic signed [DW-1:0]          dxp;
  logic signed [DW-1:0]          dxq;
  logic signed [DW-1:0]          dyp;
  logic signed [DW-1:0]          dyq;
  sri_flags_t                    flags_a;
  sri_flags_t                    flags_b;
  logic signed [PW-1:0]          xp_dy;
  logic signed [PW-1:0]          xq_dy;
  logic signed [PW-1:0]          yp_dx;
  logic signed [PW-1:0]          yq_dx;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  sri_cfg #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .x_lo      (x_lo),
    .x_hi      (x_hi),
    .y_lo      (y_lo),
    .y_hi      (y_hi)
  );

  sri_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk     (clk),
    .adv     (adv),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .x_lo    (x_lo),
    .x_hi    (x_hi),
    .y_lo    (y_lo),
    .y_hi    (y_hi),
    .dx      (dx),
    .dy      (dy),
    .dxp     (dxp),
    .dxq     (dxq),
    .dyp     (dyp),
    .dyq     (dyq),
    .flags   (flags_a)
  );

  sri_prod #(.COORD_WIDTH(COORD_WIDTH)) u_prod (
    .clk      (clk),
    .adv      (adv),
    .dx       (dx),
    .dy       (dy),
    .dxp      (dxp),
    .dxq      (dxq),
    .dyp      (dyp),
    .dyq      (dyq),
    .flags_in (flags_a),
    .xp_dy    (xp_dy),
    .xq_dy    (xq_dy),
    .yp_dx    (yp_dx),
    .yq_dx    (yq_dx),
    .flags    (flags_b)
  );

  sri_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
    .clk   (clk),
    .adv   (adv),
    .xp_dy (xp_dy),
    .xq_dy (xq_dy),
    .yp_dx (yp_dx),
    .yq_dx (yq_dx),
    .flags (flags_b),
    .hit   (hit)
  );

endmodule

/* rtl/core/sri_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the segment/rectangle test, bound to the top level.
module sri_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic hit
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit))
    else $error("stalled result transaction changed or dropped");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side is free");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted transaction did not reach the output in three cycles");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result transaction offered right after reset");

endmodule

bind segment_rect_intersect sri_checker u_sri_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit)
);

/* verif/segment_rect_checker.sv */
`timescale 1ns / 1ps
// Checker for segment_rect_intersect: predicts the hit flag of each transaction and compares.
module segment_rect_checker import sri_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          hit,
  input  logic                          drain_done,
  output int                            mismatch_count,
  output int                            hits_pending
);

  logic signed [COORD_WIDTH-1:0] corner_ax;
  logic signed [COORD_WIDTH-1:0] corner_ay;
  logic signed [COORD_WIDTH-1:0] corner_bx;
  logic signed [COORD_WIDTH-1:0] corner_by;
  bit   hit_expected_q[$];
  bit   leftover_checked;
  int   result_index;

  task report_mismatch(input string what);
    mismatch_count++;
    $display("%0t segment_rect_checker: %s", $realtime, what);
  endtask

  // segment (a1,b1)-(a2,b2) against the line a = e, restricted to b in [lo, hi]
  function automatic bit crosses_edge_line(longint a1, longint b1, longint a2, longint b2,
                                           longint e, longint lo, longint hi);
    longint amin, amax, bmin, bmax, da, db, t;
    amin = (a1 < a2) ? a1 : a2;
    amax = (a1 < a2) ? a2 : a1;
    if (e < amin || e > amax) return 1'b0;
    if (a1 == a2) begin
      bmin = (b1 < b2) ? b1 : b2;
      bmax = (b1 < b2) ? b2 : b1;
      return (bmax >= lo) && (bmin <= hi);
    end
    da = a2 - a1;
    db = b2 - b1;
    t  = e - a1;
    if (da < 0) begin
      da = -da;
      t  = -t;
    end
    // crossing b times da, compared against both ends of the edge
    return ((b1 - lo) * da + t * db >= 0) && ((hi - b1) * da - t * db >= 0);
  endfunction

  function automatic bit point_inside(longint x, longint y, longint xmin, longint xmax,
                                      longint ymin, longint ymax);
    return (x >= xmin) && (x <= xmax) && (y >= ymin) && (y <= ymax);
  endfunction

  function automatic bit segment_touches_rect(longint x1, longint y1, longint x2, longint y2);
    longint ax, ay, bx, by, xmin, xmax, ymin, ymax;
    ax = longint'(corner_ax);
    ay = longint'(corner_ay);
    bx = longint'(corner_bx);
    by = longint'(corner_by);
    xmin = (ax < bx) ? ax : bx;
    xmax = (ax < bx) ? bx : ax;
    ymin = (ay < by) ? ay : by;
    ymax = (ay < by) ? by : ay;
    return point_inside(x1, y1, xmin, xmax, ymin, ymax) ||
           point_inside(x2, y2, xmin, xmax, ymin, ymax) ||
           crosses_edge_line(y1, x1, y2, x2, ymin, xmin, xmax) ||
           crosses_edge_line(y1, x1, y2, x2, ymax, xmin, xmax) ||
           crosses_edge_line(x1, y1, x2, y2, xmin, ymin, ymax) ||
           crosses_edge_line(x1, y1, x2, y2, xmax, ymin, ymax);
  endfunction

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      corner_ax <= '0;
      corner_ay <= '0;
      corner_bx <= '0;
      corner_by <= '0;
      hit_expected_q.delete();
      leftover_checked <= 1'b0;
      result_index <= 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_A_X: corner_ax <= cfg_data;
          CFG_A_Y: corner_ay <= cfg_data;
          CFG_B_X: corner_bx <= cfg_data;
          CFG_B_Y: corner_by <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        hit_expected_q.push_back(segment_touches_rect(start_x, start_y, end_x, end_y));
      end
      if (out_valid && !out_stall) begin
        if (hit_expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no transaction outstanding",
                                    result_index));
        end else begin
          want = hit_expected_q.pop_front();
          if (hit !== want) begin
            report_mismatch($sformatf("result %0d: hit %b, expected %b",
                                      result_index, hit, want));
          end
        end
        result_index <= result_index + 1;
      end
      if (drain_done && !leftover_checked) begin
        leftover_checked <= 1'b1;
        if (hit_expected_q.size() != 0) begin
          report_mismatch($sformatf("%0d results never arrived", hit_expected_q.size()));
        end
      end
    end
    hits_pending <= hit_expected_q.size();
  end

endmodule

/* verif/tb_segment_rect_intersect.sv */
`timescale 1ns / 1ps
// Testbench top for segment_rect_intersect: stimulus, idling, watchdog and verdict.
module tb_segment_rect_intersect;
  import sri_pkg::*;

  localparam int     CW              = COORD_WIDTH_DEF;
  localparam longint COORD_MIN       = -longint'(1) <<< (CW - 1);
  localparam longint COORD_MAX       = (longint'(1) <<< (CW - 1)) - 1;
  localparam int     WATCHDOG_LIMIT  = 4000;
  localparam int     HOLD_LEN        = 400;
  localparam int     PHASES          = 8;
  localparam int     ITEMS_PER_PHASE = 225;
  localparam int     DIRECTED_COUNT  = 20;

  localparam cfg_reg_t CORNER_ORDER [4] = '{CFG_A_X, CFG_A_Y, CFG_B_X, CFG_B_Y};

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_wen      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = CFG_A_X;
  logic [CW-1:0]          cfg_data     = '0;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic signed [CW-1:0]   start_x      = '0;
  logic signed [CW-1:0]   start_y      = '0;
  logic signed [CW-1:0]   end_x        = '0;
  logic signed [CW-1:0]   end_y        = '0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic                   hit;
  logic                   drain_done   = 1'b0;
  int                     mismatch_count;
  int                     hits_pending;

  int     send_idle_pct = 0;
  int     stall_pct     = 0;
  bit     pressure_on   = 1'b0;
  int     hold_count    = 0;
  int     quiet_cycles  = 0;
  longint rect_xmin, rect_xmax, rect_ymin, rect_ymax;

  // rectangle for this list spans x -2560..2560, y -1280..1280
  longint directed_segs [DIRECTED_COUNT][4] = '{
    '{0, 0, 256, 256},
    '{0, 0, 5000, 300},
    '{-5000, 0, 5000, 0},
    '{0, -5000, 0, 5000},
    '{-2560, -3000, -2560, -1000},
    '{-2560, -3000, -2560, -1500},
    '{2560, -1280, 4000, -1280},
    '{3000, 0, 5000, 0},
    '{100, 100, 100, 100},
    '{3000, 3000, 3000, 3000},
    '{-2560, 1280, -2560, 1280},
    '{1560, 2280, 3560, 280},
    '{1561, 2281, 3561, 281},
    '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX},
    '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN},
    '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN},
    '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN},
    '{5000, 0, -5000, 0},
    '{0, 5000, 0, 1280},
    '{-3000, -5000, -2000, 5000}
  };

  always #5 clk = ~clk;

  segment_rect_intersect #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit)
  );

  segment_rect_checker #(.COORD_WIDTH(CW)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit),
    .drain_done(drain_done), .mismatch_count(mismatch_count), .hits_pending(hits_pending)
  );

  // receiver: one long hold-off once pressure is on, random stalls otherwise
  always @(posedge clk) begin
    if (pressure_on && hold_count < HOLD_LEN) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_wen || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_segment_rect_intersect: errors");
      $finish;
    end
  end

  function automatic longint rand_coord();
    logic signed [CW-1:0] r;
    r = CW'($urandom);
    return longint'(r);
  endfunction

  function automatic longint near_coord(longint lo, longint hi);
    longint margin, v;
    int     mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      v = rand_coord();
    end else if (mode == 2) begin
      v = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    end else if (mode == 3) begin
      v = ($urandom_range(0, 1) ? lo : hi) + longint'($urandom_range(0, 2)) - 1;
    end else begin
      margin = (hi - lo) / 2 + 64;
      v = lo - margin + longint'($urandom_range(0, 32'(hi - lo + 2 * margin)));
    end
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  task automatic load_rect(input longint ax, input longint ay, input longint bx,
                           input longint by);
    longint corner [4];
    corner = '{ax, ay, bx, by};
    for (int i = 0; i < 4; i++) begin
      cfg_wen   <= 1'b1;
      cfg_index <= CORNER_ORDER[i];
      cfg_data  <= corner[i][CW-1:0];
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
    rect_xmin = (ax < bx) ? ax : bx;
    rect_xmax = (ax < bx) ? bx : ax;
    rect_ymin = (ay < by) ? ay : by;
    rect_ymax = (ay < by) ? by : ay;
    // hold the input idle after the last write before returning
    repeat (2) @(posedge clk);
  endtask

  task automatic offer_segment(input longint x1, input longint y1, input longint x2,
                               input longint y2);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x  <= x1[CW-1:0];
    start_y  <= y1[CW-1:0];
    end_x    <= x2[CW-1:0];
    end_y    <= y2[CW-1:0];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_random_segment();
    longint x1, y1, x2, y2;
    int     shape;
    x1 = near_coord(rect_xmin, rect_xmax);
    y1 = near_coord(rect_ymin, rect_ymax);
    x2 = near_coord(rect_xmin, rect_xmax);
    y2 = near_coord(rect_ymin, rect_ymax);
    shape = $urandom_range(0, 9);
    case (shape)
      0, 1: x2 = x1;
      2, 3: y2 = y1;
      4: begin
        x2 = x1;
        y2 = y1;
      end
      5: begin
        x1 = $urandom_range(0, 1) ? rect_xmin : rect_xmax;
        x2 = x1;
      end
      6: begin
        y1 = $urandom_range(0, 1) ? rect_ymin : rect_ymax;
        y2 = y1;
      end
      default: ;
    endcase
    offer_segment(x1, y1, x2, y2);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (hits_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    longint cx, cy, w, h;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_rect(2560, -1280, -2560, 1280);
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      offer_segment(directed_segs[i][0], directed_segs[i][1],
                    directed_segs[i][2], directed_segs[i][3]);
    end
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 49;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 49;
        end
        default: begin
          send_idle_pct = 10;
          stall_pct    <= 10;
        end
      endcase
      cx = longint'($urandom_range(0, 2 ** 21)) - 2 ** 20;
      cy = longint'($urandom_range(0, 2 ** 21)) - 2 ** 20;
      w  = longint'($urandom_range(1, 2 ** 16));
      h  = longint'($urandom_range(1, 2 ** 16));
      case (phase)
        0: load_rect(cx - w, cy + h, cx + w, cy - h);
        1: load_rect(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        2: load_rect(cx, cy - h, cx, cy + h);
        3: load_rect(cx + w, cy, cx - w, cy);
        4: load_rect(cx, cy, cx, cy);
        5: load_rect(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        6: load_rect(COORD_MIN, COORD_MIN, COORD_MIN + 4096, COORD_MIN + 1000);
        default: load_rect(COORD_MAX, COORD_MAX - 500, COORD_MAX - 3000, COORD_MAX);
      endcase
      // hold the receiver off while the sender keeps offering
      if (phase == 0) pressure_on <= 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        offer_random_segment();
      end
      settle();
    end

    drain_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_segment_rect_intersect: clean");
    end else begin
      $display("tb_segment_rect_intersect: errors");
    end
    $finish;
  end

endmodule
